// ===== rtl/cbb_pkg.sv =====
// shared types and constants for the colour blob bounding box unit
package cbb_pkg;

   localparam int NUM_COLORS  = 5;
   localparam int COORD_W     = 10;
   localparam int COUNT_W     = 21;
   localparam int COLOR_W     = 24;
   localparam int PIX_W       = 8;
   localparam int INDEX_W     = 3;
   localparam int CSR_INDEX_W = 3;

   // frame limits, coordinates at or above these never count
   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;

   localparam logic [COUNT_W-1:0] COUNT_MAX       = 21'd1048576;
   localparam logic [COUNT_W-1:0] MIN_COUNT_RESET = 21'd50;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_COLOR_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_COUNT   = 3'd5;

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(NUM_COLORS - 1);

   // entry 0 in the low bits
   localparam logic [NUM_COLORS-1:0][COLOR_W-1:0] REF_COLOR_RESET = {
      24'h9893C9, 24'h1DFF6B, 24'h3B70B1, 24'h4B554A, 24'hE10195
   };

   typedef struct packed {
      logic [COORD_W-1:0] min_col;
      logic [COORD_W-1:0] min_row;
      logic [COORD_W-1:0] max_col;
      logic [COORD_W-1:0] max_row;
      logic [COUNT_W-1:0] count;
   } cbb_track_type;

   localparam cbb_track_type TRACK_CLEAR = '{
      min_col: {COORD_W{1'b1}},
      min_row: {COORD_W{1'b1}},
      max_col: '0,
      max_row: '0,
      count:   '0
   };

endpackage

// ===== rtl/color_blob_bounding_box_unit.sv =====
// top level of the colour blob bounding box unit
//
// one pixel word per clock comes in on req_*, with its column, row and a
// last-pixel mark; it is registered, compared against the five reference
// colours and folded into five trackers (match count saturating at 2^20,
// min/max column and row) once it leaves the input stage. the last pixel of a
// frame copies the updated trackers into a result buffer and clears them,
// so the next frame can stream in at once. the buffer then gives five
// result words on rsp_*, colour 0 first, the first one the cycle after the
// last pixel leaves the input stage, one word per cycle while rsp_ready is
// high; last_result marks colour 4. found is count > min_count and, when
// clear, the box fields read zero. pixels stream at one per clock without
// limit; the input stalls only when a frame's last pixel reaches the
// tracker stage while the previous frame's five words are still being
// taken (it may move on in the cycle the fifth word is taken). pixels with
// column >= MAX_COLS or row >= MAX_ROWS are not counted.
// the csr port is always ready: index 0..4 sets reference colour k as
// luma<<16 | cb<<8 | cr, index 5 sets min_count, other indexes are ignored;
// write it only while no frame is in flight.
module color_blob_bounding_box_unit
   import cbb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_W-1:0]       req_luma,
   input  logic [PIX_W-1:0]       req_blue_diff,
   input  logic [PIX_W-1:0]       req_red_diff,
   input  logic [COORD_W-1:0]     req_column,
   input  logic [COORD_W-1:0]     req_row,
   input  logic                   req_last_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [INDEX_W-1:0]     rsp_color_index,
   output logic                   rsp_found,
   output logic [COORD_W-1:0]     rsp_box_left,
   output logic [COORD_W-1:0]     rsp_box_top,
   output logic [COORD_W-1:0]     rsp_box_right,
   output logic [COORD_W-1:0]     rsp_box_bottom,
   output logic [COUNT_W-1:0]     rsp_pixel_count,
   output logic                   rsp_last_result,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_data
);

   // configuration registers
   logic [COLOR_W-1:0] ref_color_ff [NUM_COLORS];
   logic [COUNT_W-1:0] min_count_ff;

   // input stage
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [COLOR_W-1:0]  s1_pixel_ff;
   logic [COORD_W-1:0]  s1_col_ff;
   logic [COORD_W-1:0]  s1_row_ff;
   logic                s1_last_ff;
   logic                s1_go;
   logic                s1_inside;
   logic                req_fire;

   logic                          buf_load_ready;
   logic [NUM_COLORS-1:0]         color_hit;
   cbb_track_type [NUM_COLORS-1:0] track_next;

   // csr port never stalls
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COLORS; k++) begin
            ref_color_ff[k] <= REF_COLOR_RESET[k];
         end
         min_count_ff <= MIN_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_COUNT: begin
               min_count_ff <= csr_data[COUNT_W-1:0];
            end
            default: begin
               // colour indexes start at CSR_REF_COLOR_0, others dropped
               if (int'(csr_index - CSR_REF_COLOR_0) < NUM_COLORS) begin
                  ref_color_ff[csr_index - CSR_REF_COLOR_0] <= csr_data;
               end
            end
         endcase
      end
   end

   // a last pixel must wait until the result buffer can take a frame
   assign s1_go     = s1_valid_ff && (!s1_last_ff || buf_load_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pixel_ff <= {req_luma, req_blue_diff, req_red_diff};
         s1_col_ff   <= req_column;
         s1_row_ff   <= req_row;
         s1_last_ff  <= req_last_pixel;
      end
   end

   assign s1_inside = (32'(s1_col_ff) < 32'(MAX_COLS)) &&
                      (32'(s1_row_ff) < 32'(MAX_ROWS));

   // one exact-match compare and one tracker per colour
   for (genvar g = 0; g < NUM_COLORS; g++) begin : g_color
      assign color_hit[g] = s1_inside && (s1_pixel_ff == ref_color_ff[g]);

      cbb_tracker u_tracker (
         .clock      (clock),
         .reset      (reset),
         .advance    (s1_go),
         .hit        (color_hit[g]),
         .clear      (s1_last_ff),
         .column     (s1_col_ff),
         .row        (s1_row_ff),
         .track_next (track_next[g])
      );
   end

   cbb_result_buf u_result_buf (
      .clock           (clock),
      .reset           (reset),
      .load            (s1_go && s1_last_ff),
      .load_data       (track_next),
      .min_count       (min_count_ff),
      .load_ready      (buf_load_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_color_index (rsp_color_index),
      .rsp_found       (rsp_found),
      .rsp_box_left    (rsp_box_left),
      .rsp_box_top     (rsp_box_top),
      .rsp_box_right   (rsp_box_right),
      .rsp_box_bottom  (rsp_box_bottom),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_last_result (rsp_last_result)
   );

   a_last_gives_results: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff |=> rsp_valid && rsp_color_index == '0)
      else $error("last pixel did not start the result words");

endmodule

// ===== rtl/cbb_tracker.sv =====
// per-colour tracker: match count and bounding box of one reference colour
module cbb_tracker
   import cbb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               hit,
   input  logic               clear,
   input  logic [COORD_W-1:0] column,
   input  logic [COORD_W-1:0] row,
   output cbb_track_type      track_next
);

   cbb_track_type track_ff;
   cbb_track_type track_in;

   // state including the pixel now leaving the input stage
   always_comb begin
      track_next = track_ff;
      if (advance && hit) begin
         if (track_ff.count < COUNT_MAX) begin
            track_next.count = track_ff.count + 1'b1;
         end
         if (column < track_ff.min_col) begin
            track_next.min_col = column;
         end
         if (column > track_ff.max_col) begin
            track_next.max_col = column;
         end
         if (row < track_ff.min_row) begin
            track_next.min_row = row;
         end
         if (row > track_ff.max_row) begin
            track_next.max_row = row;
         end
      end
   end

   always_comb begin
      track_in = track_next;
      if (advance && clear) begin
         track_in = TRACK_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff <= TRACK_CLEAR;
      end else begin
         track_ff <= track_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      track_ff.count <= COUNT_MAX)
      else $error("match count above saturation limit");

   a_clear_after_frame: assert property (@(posedge clock) disable iff (reset)
      advance && clear |=> track_ff.count == '0 && track_ff.max_col == '0)
      else $error("tracker not cleared after last pixel");

endmodule

// ===== rtl/cbb_result_buf.sv =====
// result buffer: holds one frame's five results and hands them out in order
module cbb_result_buf
   import cbb_pkg::*;
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  cbb_track_type [NUM_COLORS-1:0]      load_data,
   input  logic [COUNT_W-1:0]                  min_count,
   output logic                                load_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [INDEX_W-1:0]                  rsp_color_index,
   output logic                                rsp_found,
   output logic [COORD_W-1:0]                  rsp_box_left,
   output logic [COORD_W-1:0]                  rsp_box_top,
   output logic [COORD_W-1:0]                  rsp_box_right,
   output logic [COORD_W-1:0]                  rsp_box_bottom,
   output logic [COUNT_W-1:0]                  rsp_pixel_count,
   output logic                                rsp_last_result
);

   cbb_track_type        entries_ff [NUM_COLORS];
   logic                 busy_ff;
   logic                 busy_in;
   logic [INDEX_W-1:0]   idx_ff;
   logic [INDEX_W-1:0]   idx_in;
   logic                 rsp_fire;
   cbb_track_type        cur;

   assign rsp_fire = busy_ff && rsp_ready;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (rsp_fire) begin
         if (idx_ff == LAST_INDEX) begin
            busy_in = 1'b0;
            idx_in  = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < NUM_COLORS; k++) begin
            entries_ff[k] <= load_data[k];
         end
      end
   end

   assign cur = entries_ff[idx_ff];

   // empty, or the fifth word leaves this cycle
   assign load_ready      = !busy_ff || (rsp_fire && idx_ff == LAST_INDEX);
   assign rsp_valid       = busy_ff;
   assign rsp_color_index = idx_ff;
   assign rsp_found       = cur.count > min_count;
   assign rsp_box_left    = rsp_found ? cur.min_col : '0;
   assign rsp_box_top     = rsp_found ? cur.min_row : '0;
   assign rsp_box_right   = rsp_found ? cur.max_col : '0;
   assign rsp_box_bottom  = rsp_found ? cur.max_row : '0;
   assign rsp_pixel_count = cur.count;
   assign rsp_last_result = idx_ff == LAST_INDEX;

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      load |-> !busy_ff || (rsp_ready && idx_ff == LAST_INDEX))
      else $error("result buffer overwritten before drained");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= LAST_INDEX)
      else $error("result index out of range");

endmodule
